// File: design/cra_pkg.sv
package cra_pkg;

  // field widths fixed by the stream format
  localparam int CMD_W    = 2;
  localparam int ID_W     = 4;
  localparam int UNIT_W   = 4;
  localparam int WAIT_W   = 5;
  localparam int STAT_W   = 2;
  localparam int MASK_W   = 16;
  localparam int COUNTS_W = 64;
  localparam int CFG_IDX_W = 1;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // default sizes
  localparam int NUM_RESOURCES_DEF = 16;
  localparam int NUM_PROCESSES_DEF = 16;

  // reset values of the configuration registers
  localparam logic [MASK_W-1:0]   SHAREABLE_RST = '0;
  localparam logic [COUNTS_W-1:0] COUNTS_RST    = 64'h5555_5555_5555_5555;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHAREABLE_MASK  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INSTANCE_COUNTS = 1'b1;

  // wait mark meaning the process waits on nothing
  localparam logic [WAIT_W-1:0] NOT_WAITING = 5'd31;

  typedef enum logic [CMD_W-1:0] {
    CMD_REQUEST     = 2'd0,
    CMD_RELEASE     = 2'd1,
    CMD_RELEASE_ALL = 2'd2,
    CMD_RELIEVE     = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_WAITING   = 2'd1,
    STAT_REFUSED   = 2'd2,
    STAT_NO_WAITER = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_SCAN,
    S_WAKE_RD,
    S_WAKE_WR,
    S_RESULT
  } state_t;

  typedef struct packed {
    cmd_t            cmd;
    logic [ID_W-1:0] process;
    logic [ID_W-1:0] resource;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   woken_process;
    logic [WAIT_W-1:0] waiters_on_resource;
  } res_t;

endpackage

// File: design/cra_engine.sv
module cra_engine #(
  parameter int NUM_RESOURCES = cra_pkg::NUM_RESOURCES_DEF,
  parameter int NUM_PROCESSES = cra_pkg::NUM_PROCESSES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [cra_pkg::MASK_W-1:0]    shareable_mask,
  input  logic [cra_pkg::COUNTS_W-1:0]  instance_counts,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  cra_pkg::req_t                 req,
  output logic                          res_valid,
  input  logic                          res_ready,
  output cra_pkg::res_t                 res
);

  localparam int RW      = $clog2(NUM_RESOURCES);
  localparam int PW      = $clog2(NUM_PROCESSES);
  localparam int HA_W    = PW + RW;
  localparam int H_DEPTH = 1 << HA_W;
  localparam int CNT_MAX = (NUM_RESOURCES > NUM_PROCESSES) ? NUM_RESOURCES : NUM_PROCESSES;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  localparam int UW = cra_pkg::UNIT_W;
  localparam int WW = cra_pkg::WAIT_W;
  localparam int IW = cra_pkg::ID_W;

  // holdings per process and resource, one entry per {process, resource}
  logic [UW-1:0] hold_mem [H_DEPTH];
  logic [UW-1:0] rdata_r;
  logic [HA_W-1:0] mem_raddr, mem_waddr;
  logic [UW-1:0] mem_wdata;
  logic mem_we;

  // small per-resource and per-process tables
  logic [UW-1:0] units_r [NUM_RESOURCES];
  logic [WW-1:0] wc_r    [NUM_RESOURCES];
  logic [WW-1:0] won_r   [NUM_PROCESSES];

  cra_pkg::state_t state_r, state_nxt;
  cra_pkg::cmd_t   cmd_r;
  logic [IW-1:0]   proc_r, res_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [HA_W-1:0] clr_r, clr_nxt;
  cra_pkg::status_t status_r, status_nxt;
  logic [IW-1:0]   woken_r, woken_nxt;

  // table update strobes
  logic          units_we;
  logic [RW-1:0] units_widx;
  logic [UW-1:0] units_wval;
  logic          wc_dec_en, wc_inc_en;
  logic [RW-1:0] wc_dec_idx;
  logic          won_we;
  logic [PW-1:0] won_widx;
  logic [WW-1:0] won_wval;

  // decode of the held item
  logic          p_ok, r_ok, share, has_free;
  logic [PW-1:0] pi;
  logic [RW-1:0] ri;
  logic [UW-1:0] total, units_cur;
  logic [WW-1:0] w_cur;
  logic [RW-1:0] prev_idx;
  logic [PW-1:0] scan_idx;
  logic          scan_hit;

  assign p_ok      = {1'b0, proc_r} < (IW+1)'(NUM_PROCESSES);
  assign r_ok      = {1'b0, res_r} < (IW+1)'(NUM_RESOURCES);
  assign pi        = proc_r[PW-1:0];
  assign ri        = res_r[RW-1:0];
  assign share     = shareable_mask[res_r];
  assign total     = instance_counts[res_r * UW +: UW];
  assign units_cur = units_r[ri];
  assign has_free  = total > units_cur;
  assign w_cur     = won_r[pi];
  assign prev_idx  = RW'(cnt_r - CNT_W'(1));
  assign scan_idx  = cnt_r[PW-1:0];
  assign scan_hit  = (won_r[scan_idx] == {1'b0, res_r})
                   && ((WW)'(cnt_r) != {1'b0, proc_r});

  // sequencer: next state, memory port and table updates
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    clr_nxt    = clr_r;
    status_nxt = status_r;
    woken_nxt  = woken_r;
    mem_raddr  = {pi, ri};
    mem_we     = 1'b0;
    mem_waddr  = {pi, ri};
    mem_wdata  = rdata_r;
    units_we   = 1'b0;
    units_widx = ri;
    units_wval = units_cur;
    wc_dec_en  = 1'b0;
    wc_dec_idx = ri;
    wc_inc_en  = 1'b0;
    won_we     = 1'b0;
    won_widx   = pi;
    won_wval   = cra_pkg::NOT_WAITING;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    case (state_r)
      cra_pkg::S_CLEAR: begin
        mem_we    = 1'b0 | 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + HA_W'(1);
        if (clr_r == {HA_W{1'b1}}) state_nxt = cra_pkg::S_IDLE;
      end
      cra_pkg::S_IDLE: begin
        req_ready = 1'b1;
        mem_raddr = {req.process[PW-1:0], req.resource[RW-1:0]};
        if (req_valid) begin
          state_nxt  = cra_pkg::S_EXEC;
          cnt_nxt    = '0;
          woken_nxt  = '0;
          status_nxt = cra_pkg::STAT_REFUSED;
        end
      end
      cra_pkg::S_EXEC: begin
        state_nxt = cra_pkg::S_RESULT;
        case (cmd_r)
          cra_pkg::CMD_REQUEST: begin
            if (p_ok && r_ok) begin
              if (share) begin
                status_nxt = cra_pkg::STAT_OK;
              end else if (has_free) begin
                units_we   = 1'b1;
                units_wval = units_cur + UW'(1);
                mem_we     = 1'b1;
                mem_wdata  = rdata_r + UW'(1);
                status_nxt = cra_pkg::STAT_OK;
              end else begin
                status_nxt = cra_pkg::STAT_WAITING;
                if (w_cur != {1'b0, res_r}) begin
                  // move the wait mark to this resource
                  if (!w_cur[WW-1] && wc_r[w_cur[RW-1:0]] != '0) begin
                    wc_dec_en  = 1'b1;
                    wc_dec_idx = w_cur[RW-1:0];
                  end
                  won_we    = 1'b1;
                  won_wval  = {1'b0, res_r};
                  wc_inc_en = 1'b1;
                end
              end
            end
          end
          cra_pkg::CMD_RELEASE: begin
            if (p_ok && r_ok && !share && rdata_r != '0) begin
              mem_we    = 1'b1;
              mem_wdata = rdata_r - UW'(1);
              if (units_cur != '0) begin
                units_we   = 1'b1;
                units_wval = units_cur - UW'(1);
              end
              status_nxt = cra_pkg::STAT_OK;
            end
          end
          cra_pkg::CMD_RELEASE_ALL: begin
            if (p_ok) state_nxt = cra_pkg::S_WALK;
          end
          cra_pkg::CMD_RELIEVE: begin
            if (r_ok) begin
              status_nxt = cra_pkg::STAT_NO_WAITER;
              if (share || has_free) state_nxt = cra_pkg::S_SCAN;
            end
          end
          default: state_nxt = cra_pkg::S_RESULT;
        endcase
      end
      cra_pkg::S_WALK: begin
        // write back the entry read last cycle, read the next one
        if (cnt_r != '0) begin
          units_we   = 1'b1;
          units_widx = prev_idx;
          units_wval = (units_r[prev_idx] > rdata_r) ? units_r[prev_idx] - rdata_r : '0;
          mem_we     = 1'b1;
          mem_waddr  = {pi, prev_idx};
          mem_wdata  = '0;
        end
        if (cnt_r < CNT_W'(NUM_RESOURCES)) begin
          mem_raddr = {pi, cnt_r[RW-1:0]};
          cnt_nxt   = cnt_r + CNT_W'(1);
        end else begin
          if (!w_cur[WW-1] && wc_r[w_cur[RW-1:0]] != '0) begin
            wc_dec_en  = 1'b1;
            wc_dec_idx = w_cur[RW-1:0];
          end
          won_we     = 1'b1;
          status_nxt = cra_pkg::STAT_OK;
          state_nxt  = cra_pkg::S_RESULT;
        end
      end
      cra_pkg::S_SCAN: begin
        // one process per cycle, lowest number first
        if (cnt_r == CNT_W'(NUM_PROCESSES)) begin
          state_nxt = cra_pkg::S_RESULT;
        end else if (scan_hit) begin
          if (wc_r[ri] != '0) wc_dec_en = 1'b1;
          won_we     = 1'b1;
          won_widx   = scan_idx;
          status_nxt = cra_pkg::STAT_OK;
          woken_nxt  = IW'(cnt_r);
          state_nxt  = share ? cra_pkg::S_RESULT : cra_pkg::S_WAKE_RD;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      cra_pkg::S_WAKE_RD: begin
        mem_raddr = {woken_r[PW-1:0], ri};
        state_nxt = cra_pkg::S_WAKE_WR;
      end
      cra_pkg::S_WAKE_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = {woken_r[PW-1:0], ri};
        mem_wdata  = rdata_r + UW'(1);
        units_we   = 1'b1;
        units_wval = units_cur + UW'(1);
        state_nxt  = cra_pkg::S_RESULT;
      end
      cra_pkg::S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = cra_pkg::S_IDLE;
      end
      default: state_nxt = cra_pkg::S_IDLE;
    endcase
  end

  // result fields
  assign res.status              = status_r;
  assign res.woken_process       = woken_r;
  assign res.waiters_on_resource = r_ok ? wc_r[ri] : '0;

  // holdings memory
  always_ff @(posedge clk) begin
    if (mem_we) hold_mem[mem_waddr] <= mem_wdata;
    rdata_r <= hold_mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cra_pkg::S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // held item and result payload
  always_ff @(posedge clk) begin
    if (state_r == cra_pkg::S_IDLE && req_valid) begin
      cmd_r  <= req.cmd;
      proc_r <= req.process;
      res_r  <= req.resource;
    end
    status_r <= status_nxt;
    woken_r  <= woken_nxt;
  end

  // per-resource and per-process tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_RESOURCES; i++) begin
        units_r[i] <= '0;
        wc_r[i]    <= '0;
      end
      for (int i = 0; i < NUM_PROCESSES; i++) won_r[i] <= cra_pkg::NOT_WAITING;
    end else begin
      if (units_we) units_r[units_widx] <= units_wval;
      if (wc_dec_en) wc_r[wc_dec_idx] <= wc_r[wc_dec_idx] - WW'(1);
      if (wc_inc_en) wc_r[ri] <= wc_r[ri] + WW'(1);
      if (won_we) won_r[won_widx] <= won_wval;
    end
  end

endmodule

// File: design/counted_resource_allocator_top.sv
// Counted resource allocator: a counting-semaphore manager for up to
// NUM_PROCESSES processes and NUM_RESOURCES resources.
// Input stream in_*: one command per transfer (request, release one,
// release all, relieve a waiter) naming a process and a resource.
// Output stream out_*: exactly one result per command, in order: status,
// woken process and the waiter count of the addressed resource.
// cfg_*: write-only registers, index 0 shareable mask, index 1 packed unit
// totals; write them only while no command is in flight.
// Items are handled one at a time. Release all walks the holdings one entry
// per cycle, reading the next entry while writing back the previous one.
// Relieve with no free unit on a non-shareable resource answers without a
// scan; else the wait marks are scanned one process per cycle, then, for a
// non-shareable resource, the woken process's holding is read and written.
// in_tready returns in the same cycle that the result appears in the output
// register.
// Reset: synchronous, active low. The holdings memory is then cleared one
// entry per cycle, all 2^(clog2(NUM_PROCESSES) + clog2(NUM_RESOURCES)) entries
// (256 at the defaults), with in_tready low; cfg writes are taken throughout.
// Output stall: the result sits in the output register; the next command is
// still accepted and processed, and its result waits until the register frees.
module counted_resource_allocator_top #(
  parameter int NUM_RESOURCES = cra_pkg::NUM_RESOURCES_DEF,
  parameter int NUM_PROCESSES = cra_pkg::NUM_PROCESSES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // command stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cra_pkg::IN_TDATA_W-1:0]    in_tdata,   // command[1:0], process[5:2], resource[9:6]
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cra_pkg::OUT_TDATA_W-1:0]   out_tdata,  // status[1:0], woken_process[5:2],
                                                        // waiters_on_resource[10:6]
  // configuration writes
  input  logic                              cfg_wr_en,
  input  logic [cra_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cra_pkg::COUNTS_W-1:0]      cfg_wdata
);

  logic [cra_pkg::MASK_W-1:0]   shareable_r;
  logic [cra_pkg::COUNTS_W-1:0] counts_r;
  cra_pkg::req_t req;
  cra_pkg::res_t res;
  logic res_valid, res_ready;
  logic out_valid_r;
  cra_pkg::res_t out_res_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shareable_r <= cra_pkg::SHAREABLE_RST;
      counts_r    <= cra_pkg::COUNTS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cra_pkg::CFG_SHAREABLE_MASK:  shareable_r <= cfg_wdata[cra_pkg::MASK_W-1:0];
        cra_pkg::CFG_INSTANCE_COUNTS: counts_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // unpack the command
  assign req.cmd      = cra_pkg::cmd_t'(in_tdata[1:0]);
  assign req.process  = in_tdata[5:2];
  assign req.resource = in_tdata[9:6];

  cra_engine #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .NUM_PROCESSES (NUM_PROCESSES)
  ) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .shareable_mask  (shareable_r),
    .instance_counts (counts_r),
    .req_valid       (in_tvalid),
    .req_ready       (in_tready),
    .req             (req),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.waiters_on_resource, out_res_r.woken_process,
                       out_res_r.status};

  // one command at a time: the engine leaves idle after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("command accepted while another is in flight");

  // a woken process is reported only with a grant
  a_woken_granted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.woken_process != '0) |-> (out_res_r.status == cra_pkg::STAT_OK))
    else $error("woken process reported without a grant");

  // each process waits on at most one resource
  a_waiters_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_res_r.waiters_on_resource} <= 6'(NUM_PROCESSES)))
    else $error("waiter count exceeds number of processes");

endmodule

// File: tb/tb_counted_resource_allocator_top.sv
module tb_counted_resource_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cra_pkg::*;

  localparam int NRES        = NUM_RESOURCES_DEF;
  localparam int NPROC       = NUM_PROCESSES_DEF;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 135;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 40;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // command[1:0], process[5:2], resource[9:6]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // status[1:0], woken_process[5:2],
                                             // waiters_on_resource[10:6]
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [COUNTS_W-1:0]    cfg_wdata  = '0;

  counted_resource_allocator_top #(
    .NUM_RESOURCES(NRES),
    .NUM_PROCESSES(NPROC)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // allocator bookkeeping mirrored in the bench
  logic [MASK_W-1:0]   share_mask;
  logic [COUNTS_W-1:0] unit_totals;
  logic [7:0]          in_use     [NRES];
  logic [7:0]          held       [NPROC][NRES];
  logic [WAIT_W-1:0]   wait_mark  [NPROC];
  logic [WAIT_W-1:0]   waiter_cnt [NRES];

  res_t        pending_results[$];
  int unsigned cmds_taken = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;

  // hand-written result for the command currently offered
  bit   row_typed = 1'b0;
  res_t row_want  = '0;

  typedef struct {
    bit                   is_cfg;
    cmd_t                 cmd;
    logic [ID_W-1:0]      proc;
    logic [ID_W-1:0]      rsrc;
    bit                   typed;
    res_t                 want;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [COUNTS_W-1:0]  cfg_val;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic int unsigned free_units(int unsigned r);
    int unsigned total;
    total = unit_totals[4*r +: 4];
    return (total > in_use[r]) ? total - in_use[r] : 0;
  endfunction

  function automatic void drop_wait(int unsigned p);
    int unsigned w;
    w = wait_mark[p];
    if (w < NRES && waiter_cnt[w] > 0) waiter_cnt[w]--;
    wait_mark[p] = NOT_WAITING;
  endfunction

  // one allocator command: updates the books and returns its result
  function automatic res_t allocate_step(cmd_t cmd, int unsigned p, int unsigned r);
    res_t        res;
    bit          p_ok;
    bit          r_ok;
    bit          share;
    bit          found;
    int unsigned h;
    p_ok = (p < NPROC);
    r_ok = (r < NRES);
    res.status = STAT_REFUSED;
    res.woken_process = '0;
    case (cmd)
      CMD_REQUEST: begin
        if (p_ok && r_ok) begin
          if (share_mask[r]) begin
            res.status = STAT_OK;
          end else if (free_units(r) > 0) begin
            in_use[r]++;
            held[p][r]++;
            res.status = STAT_OK;
          end else begin
            // a wait moves to the newly named resource
            if (wait_mark[p] != r) begin
              drop_wait(p);
              wait_mark[p] = WAIT_W'(r);
              waiter_cnt[r]++;
            end
            res.status = STAT_WAITING;
          end
        end
      end
      CMD_RELEASE: begin
        if (p_ok && r_ok && !share_mask[r] && held[p][r] > 0) begin
          held[p][r]--;
          if (in_use[r] > 0) in_use[r]--;
          res.status = STAT_OK;
        end
      end
      CMD_RELEASE_ALL: begin
        if (p_ok) begin
          for (int i = 0; i < NRES; i++) begin
            h = held[p][i];
            in_use[i] = (in_use[i] > h) ? 8'(in_use[i] - h) : 8'd0;
            held[p][i] = '0;
          end
          drop_wait(p);
          res.status = STAT_OK;
        end
      end
      default: begin
        // relieve: lowest waiter other than the named process
        if (r_ok) begin
          share = share_mask[r];
          found = 1'b0;
          res.status = STAT_NO_WAITER;
          if (share || free_units(r) > 0) begin
            for (int i = 0; i < NPROC; i++) begin
              if (!found && i != p && wait_mark[i] == r) begin
                drop_wait(i);
                if (!share) begin
                  in_use[r]++;
                  held[i][r]++;
                end
                res.status = STAT_OK;
                res.woken_process = ID_W'(i);
                found = 1'b1;
              end
            end
          end
        end
      end
    endcase
    res.waiters_on_resource = r_ok ? waiter_cnt[r] : '0;
    return res;
  endfunction

  // sample both streams and the register port at the rising edge
  always @(posedge clk) begin : monitor
    res_t want;
    res_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else if (rst_n) begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_SHAREABLE_MASK) share_mask = cfg_wdata[MASK_W-1:0];
        else unit_totals = cfg_wdata;
      end
      // result transfer: compare with the oldest pending result
      if (out_tvalid && out_tready) begin
        got.status              = status_t'(out_tdata[1:0]);
        got.woken_process       = out_tdata[5:2];
        got.waiters_on_resource = out_tdata[10:6];
        if (pending_results.size() == 0) begin
          $error("unrequested result: status %0d woken_process %0d waiters_on_resource %0d",
                 got.status, got.woken_process, got.waiters_on_resource);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
          end
          if (got.woken_process !== want.woken_process) begin
            $error("woken_process: expected %0d, actual %0d",
                   want.woken_process, got.woken_process);
            errors++;
          end
          if (got.waiters_on_resource !== want.waiters_on_resource) begin
            $error("waiters_on_resource: expected %0d, actual %0d",
                   want.waiters_on_resource, got.waiters_on_resource);
            errors++;
          end
        end
      end
      // command transfer: predict its result
      if (in_tvalid && in_tready) begin
        want = allocate_step(cmd_t'(in_tdata[1:0]), in_tdata[5:2], in_tdata[9:6]);
        if (row_typed) want = row_want;
        pending_results.push_back(want);
        cmds_taken++;
      end
    end
  end

  // result side back-pressure: short and long stalls, long open stretches
  initial begin : out_pacing
    int unsigned hold;
    int unsigned roll;
    @(negedge clk);
    forever begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        out_tready <= 1'b1;
        hold = $urandom_range(100, 300);
      end else if (roll < 55) begin
        out_tready <= 1'b1;
        hold = $urandom_range(1, 8);
      end else if (roll < 93) begin
        out_tready <= 1'b0;
        hold = $urandom_range(1, 3);
      end else begin
        out_tready <= 1'b0;
        hold = $urandom_range(15, 60);
      end
      repeat (hold) @(negedge clk);
    end
  end

  function automatic int unsigned pick_gap(int unsigned mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (mode == 1) return (roll < 60) ? 0 : $urandom_range(1, 3);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_cmd(cmd_t cmd, int unsigned p, int unsigned r, bit typed = 1'b0,
                                  status_t st = STAT_OK, int unsigned waiters = 0);
    plan_row_t row;
    row = '{cmd: CMD_REQUEST, default: '0};
    row.cmd   = cmd;
    row.proc  = ID_W'(p);
    row.rsrc  = ID_W'(r);
    row.typed = typed;
    row.want  = '{status: st, woken_process: '0, waiters_on_resource: WAIT_W'(waiters)};
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [COUNTS_W-1:0] val);
    plan_row_t row;
    row = '{cmd: CMD_REQUEST, default: '0};
    row.is_cfg  = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    plan.push_back(row);
  endfunction

  // offer one command and hold it until the transfer happens
  task automatic send_cmd(cmd_t cmd, logic [ID_W-1:0] p, logic [ID_W-1:0] r,
                          int unsigned gap, bit typed, res_t want);
    int unsigned taken;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    taken = cmds_taken;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({r, p, cmd});
    row_typed = typed;
    row_want  = want;
    do @(negedge clk); while (cmds_taken == taken);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNTS_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    cmd_t              cmd;
    logic [ID_W-1:0]   p;
    logic [ID_W-1:0]   r;
    logic [MASK_W-1:0] mask;
    logic [COUNTS_W-1:0] counts;
    int unsigned       roll;
    int unsigned       start;
    int unsigned       idx;
    int unsigned       res_hi;
    int unsigned       proc_hi;
    int unsigned       mode;
    int unsigned       mid;
    bit                found;

    // books start from the reset state
    share_mask  = SHAREABLE_RST;
    unit_totals = COUNTS_RST;
    for (int i = 0; i < NRES; i++) begin
      in_use[i]     = '0;
      waiter_cnt[i] = '0;
    end
    for (int i = 0; i < NPROC; i++) begin
      wait_mark[i] = NOT_WAITING;
      for (int j = 0; j < NRES; j++) held[i][j] = '0;
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed plan: r0 has 2 units, r1 one, r2 none, r3 shareable, r15 fifteen
    add_cfg(CFG_SHAREABLE_MASK, 64'h0008);
    add_cfg(CFG_INSTANCE_COUNTS, 64'hF555_5555_5555_5012);
    add_cmd(CMD_RELEASE,     0,  0,  1'b1, STAT_REFUSED,   0);  // nothing held
    add_cmd(CMD_RELIEVE,     0,  0,  1'b1, STAT_NO_WAITER, 0);
    add_cmd(CMD_RELEASE_ALL, 15, 15, 1'b1, STAT_OK,        0);
    add_cmd(CMD_REQUEST,     0,  0,  1'b1, STAT_OK,        0);
    add_cmd(CMD_REQUEST,     1,  0,  1'b1, STAT_OK,        0);
    add_cmd(CMD_REQUEST,     2,  0,  1'b1, STAT_WAITING,   1);
    add_cmd(CMD_REQUEST,     2,  0,  1'b1, STAT_WAITING,   1);  // same wait again
    add_cmd(CMD_REQUEST,     2,  2);                            // wait moves to r2
    add_cmd(CMD_REQUEST,     3,  0);
    add_cmd(CMD_REQUEST,     4,  3,  1'b1, STAT_OK,        0);  // shareable grant
    add_cmd(CMD_RELEASE,     4,  3,  1'b1, STAT_REFUSED,   0);  // shareable release
    add_cmd(CMD_RELIEVE,     0,  0);                            // no free unit
    add_cmd(CMD_RELEASE,     0,  0);
    add_cmd(CMD_RELIEVE,     3,  0);                            // only waiter is skipped
    add_cmd(CMD_RELIEVE,     0,  0);                            // wakes p3
    add_cmd(CMD_REQUEST,     6,  1);
    add_cmd(CMD_REQUEST,     7,  1);
    add_cmd(CMD_REQUEST,     8,  1);
    add_cmd(CMD_RELIEVE,     0,  2);
    add_cmd(CMD_RELEASE_ALL, 6,  9);
    add_cmd(CMD_RELIEVE,     7,  1);                            // skips p7, wakes p8
    add_cmd(CMD_RELEASE_ALL, 2,  2);
    add_cmd(CMD_REQUEST,     15, 15);
    add_cfg(CFG_SHAREABLE_MASK, 64'h000A);
    add_cmd(CMD_RELIEVE,     15, 1);                            // shareable wake, no unit
    add_cmd(CMD_RELEASE,     8,  1);
    add_cfg(CFG_INSTANCE_COUNTS, 64'h0);                        // totals below use
    add_cmd(CMD_RELIEVE,     0,  0);
    add_cmd(CMD_RELEASE_ALL, 0,  0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drain();
        write_reg(plan[i].cfg_idx, plan[i].cfg_val);
      end else begin
        send_cmd(plan[i].cmd, plan[i].proc, plan[i].rsrc, pick_gap(2),
                 plan[i].typed, plan[i].want);
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin mask = '0;       counts = 64'h1111_1111_1111_1111; end
        1: begin mask = '0;       counts = '1; end
        2: begin mask = '0;       counts = '0; end
        3: begin mask = '1;       counts = {$urandom, $urandom}; end
        4: begin mask = MASK_W'($urandom); counts = {$urandom, $urandom}; end
        5: begin mask = MASK_W'($urandom & 16'h00FF); counts = 64'h2222_2222_2222_2222; end
        6: begin mask = 16'hAAAA; counts = {$urandom, $urandom} & 64'h3333_3333_3333_3333; end
        default: begin mask = MASK_W'($urandom); counts = {$urandom, $urandom}; end
      endcase
      wait_drain();
      write_reg(CFG_SHAREABLE_MASK, COUNTS_W'(mask));
      write_reg(CFG_INSTANCE_COUNTS, counts);

      case (ph % 4)
        0: res_hi = 3;
        1: res_hi = 15;
        2: res_hi = 1;
        default: res_hi = 7;
      endcase
      proc_hi = (ph % 3 == 1) ? 5 : 15;
      mode = ph % 3;
      mid = $urandom_range(20, PHASE_ITEMS - 20);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off until every result is back, once per phase
        if (n == mid) wait_drain();
        roll = $urandom_range(0, 99);
        p = ID_W'($urandom_range(0, proc_hi));
        r = ID_W'($urandom_range(0, res_hi));
        if (roll < 5) begin
          cmd = cmd_t'($urandom_range(0, 3));
          p = ID_W'($urandom_range(0, 15));
          r = ID_W'($urandom_range(0, 15));
        end else if (roll < 47) begin
          cmd = CMD_REQUEST;
        end else if (roll < 72) begin
          cmd = CMD_RELEASE;
          // mostly release a unit that is actually held
          if ($urandom_range(0, 3) != 0) begin
            start = $urandom_range(0, NPROC*NRES - 1);
            found = 1'b0;
            for (int k = 0; k < NPROC*NRES; k++) begin
              idx = (start + k) % (NPROC*NRES);
              if (!found && held[idx / NRES][idx % NRES] > 0) begin
                p = ID_W'(idx / NRES);
                r = ID_W'(idx % NRES);
                found = 1'b1;
              end
            end
          end
        end else if (roll < 81) begin
          cmd = CMD_RELEASE_ALL;
        end else begin
          cmd = CMD_RELIEVE;
          // mostly aim at a resource that has a waiter
          if ($urandom_range(0, 4) != 0) begin
            start = $urandom_range(0, NPROC - 1);
            found = 1'b0;
            for (int k = 0; k < NPROC; k++) begin
              idx = (start + k) % NPROC;
              if (!found && wait_mark[idx] != NOT_WAITING) begin
                r = wait_mark[idx][ID_W-1:0];
                if ($urandom_range(0, 3) == 0) p = ID_W'(idx);
                found = 1'b1;
              end
            end
          end
        end
        send_cmd(cmd, p, r, pick_gap(mode), 1'b0, '0);
      end
    end

    // let the last results come home
    wait_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
